// ===== hw/rtl/tsbc_pkg.sv =====
`default_nettype none

package tsbc_pkg;

	// Opcodes and syscall numbers
	localparam logic [7:0] OPC_SYSCALL = 8'h00;
	localparam logic [7:0] OPC_PUSH    = 8'h03;
	localparam logic [7:0] OPC_ADD     = 8'h0C;
	localparam logic [7:0] SYS_WRITE   = 8'h00;
	localparam logic [7:0] SYS_EXIT    = 8'h01;

	localparam logic CMD_LOAD = 1'b0;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_BAD_OPCODE  = 3'd1,
		ST_BAD_SYSCALL = 3'd2,
		ST_UNDERFLOW   = 3'd3,
		ST_OVERFLOW    = 3'd4
	} status_t;

	// Microprogram addresses
	typedef enum logic [4:0] {
		U_CLR, U_IDLE, U_DISP, U_EXEC,
		U_PUSH_A, U_PUSH_B, U_PUSH_C, U_PUSH_D, U_PUSH_E,
		U_OVF, U_UNDER, U_BADOP,
		U_ADD0, U_ADD1, U_ADD2,
		U_SYS0, U_BADSYS,
		U_WR0, U_WR1, U_WR2, U_WR3,
		U_EXIT0,
		U_EMIT0, U_EMIT1,
		U_LOAD0, U_LOAD1, U_LOAD2,
		U_FIN
	} uaddr_t;

	typedef enum logic [1:0] {J_NEXT, J_GOTO, J_WAIT, J_DISP} jump_t;
	typedef enum logic [1:0] {C_NO_XFER, C_MOD_BUSY, C_OUT_BUSY, C_CLR_MORE} cond_t;
	typedef enum logic [1:0] {D_CMD, D_OP, D_SYS} disp_t;
	typedef enum logic [1:0] {PA_IA, PA_WP, PA_LOAD, PA_CLR} pm_addr_t;
	typedef enum logic [1:0] {SA_PUSH, SA_TOP, SA_TOP1, SA_TOP2} stk_addr_t;
	typedef enum logic [2:0] {DP_HOLD, DP_INC, DP_DEC1, DP_DEC2, DP_DEC3} dep_op_t;
	typedef enum logic [1:0] {IA_HOLD, IA_ADV1, IA_ADV5} ia_op_t;

	typedef enum logic [3:0] {
		ACT_NONE, ACT_BEGIN, ACT_SHIFT, ACT_TAKE_A, ACT_SUM, ACT_SETLEN,
		ACT_MOD_LOAD, ACT_MOD_PTR, ACT_SETWP, ACT_SETEXIT, ACT_EMIT_ADV,
		ACT_OBYTE, ACT_CLRINC, ACT_DELIVER
	} act_t;

	typedef struct packed {
		jump_t     jt;
		cond_t     cond;
		disp_t     dsel;
		uaddr_t    target;
		pm_addr_t  pa;
		logic [2:0] ia_off;
		logic      pm_we;
		stk_addr_t sa;
		logic      sk_we;
		dep_op_t   dep;
		ia_op_t    ia;
		logic      st_we;
		status_t   st;
		act_t      act;
		logic      accept;
	} ctrl_t;

	// Datapath conditions seen by the sequencer
	typedef struct packed {
		logic       in_xfer;
		logic       mod_busy;
		logic       out_busy;
		logic       clr_more;
		logic       cmd_load;
		logic       stopped;
		logic       wrem_nz;
		logic [7:0] op_code;
		logic [7:0] sys_num;
		logic       dep_full;
		logic       dep_lt1;
		logic       dep_lt2;
		logic       dep_lt3;
	} seq_flags_t;

	function automatic ctrl_t ucode_rom(input uaddr_t ua);
		ctrl_t w;
		w.jt     = J_NEXT;
		w.cond   = C_NO_XFER;
		w.dsel   = D_CMD;
		w.target = U_IDLE;
		w.pa     = PA_IA;
		w.ia_off = 3'd0;
		w.pm_we  = 1'b0;
		w.sa     = SA_TOP;
		w.sk_we  = 1'b0;
		w.dep    = DP_HOLD;
		w.ia     = IA_HOLD;
		w.st_we  = 1'b0;
		w.st     = ST_OK;
		w.act    = ACT_NONE;
		w.accept = 1'b0;
		case (ua)
			U_CLR: begin
				w.pa = PA_CLR; w.pm_we = 1'b1; w.act = ACT_CLRINC;
				w.jt = J_WAIT; w.cond = C_CLR_MORE; w.target = U_IDLE;
			end
			U_IDLE: begin
				w.accept = 1'b1;
				w.jt = J_WAIT; w.cond = C_NO_XFER; w.target = U_DISP;
			end
			U_DISP: begin
				w.pa = PA_IA; w.ia_off = 3'd0; w.act = ACT_BEGIN;
				w.st_we = 1'b1; w.st = ST_OK;
				w.jt = J_DISP; w.dsel = D_CMD;
			end
			U_EXEC: begin
				w.pa = PA_IA; w.ia_off = 3'd1; w.sa = SA_TOP;
				w.jt = J_DISP; w.dsel = D_OP;
			end
			U_PUSH_A: begin
				w.act = ACT_SHIFT; w.ia_off = 3'd2;
			end
			U_PUSH_B: begin
				w.act = ACT_SHIFT; w.ia_off = 3'd3;
			end
			U_PUSH_C: begin
				w.act = ACT_SHIFT; w.ia_off = 3'd4;
			end
			U_PUSH_D: begin
				w.act = ACT_SHIFT;
			end
			U_PUSH_E: begin
				w.sa = SA_PUSH; w.sk_we = 1'b1; w.dep = DP_INC; w.ia = IA_ADV5;
				w.jt = J_GOTO; w.target = U_FIN;
			end
			U_OVF: begin
				w.st_we = 1'b1; w.st = ST_OVERFLOW; w.ia = IA_ADV5;
				w.jt = J_GOTO; w.target = U_FIN;
			end
			U_UNDER: begin
				w.st_we = 1'b1; w.st = ST_UNDERFLOW; w.ia = IA_ADV1;
				w.jt = J_GOTO; w.target = U_FIN;
			end
			U_BADOP: begin
				w.st_we = 1'b1; w.st = ST_BAD_OPCODE; w.ia = IA_ADV1;
				w.jt = J_GOTO; w.target = U_FIN;
			end
			U_ADD0: begin
				w.act = ACT_TAKE_A; w.sa = SA_TOP1;
			end
			U_ADD1: begin
				w.act = ACT_SUM;
			end
			U_ADD2: begin
				w.sa = SA_TOP1; w.sk_we = 1'b1; w.dep = DP_DEC1; w.ia = IA_ADV1;
				w.jt = J_GOTO; w.target = U_FIN;
			end
			U_SYS0: begin
				w.sa = SA_TOP1;
				w.jt = J_DISP; w.dsel = D_SYS;
			end
			U_BADSYS: begin
				w.dep = DP_DEC1; w.st_we = 1'b1; w.st = ST_BAD_SYSCALL; w.ia = IA_ADV1;
				w.jt = J_GOTO; w.target = U_FIN;
			end
			U_WR0: begin
				w.act = ACT_SETLEN; w.sa = SA_TOP2;
			end
			U_WR1: begin
				w.act = ACT_MOD_PTR; w.dep = DP_DEC3;
			end
			U_WR2: begin
				w.jt = J_WAIT; w.cond = C_MOD_BUSY; w.target = U_WR3;
			end
			U_WR3: begin
				w.act = ACT_SETWP; w.ia = IA_ADV1;
				w.jt = J_GOTO; w.target = U_FIN;
			end
			U_EXIT0: begin
				w.act = ACT_SETEXIT; w.dep = DP_DEC2;
				w.jt = J_GOTO; w.target = U_FIN;
			end
			U_EMIT0: begin
				w.pa = PA_WP; w.act = ACT_EMIT_ADV;
			end
			U_EMIT1: begin
				w.act = ACT_OBYTE;
				w.jt = J_GOTO; w.target = U_FIN;
			end
			U_LOAD0: begin
				w.act = ACT_MOD_LOAD;
			end
			U_LOAD1: begin
				w.jt = J_WAIT; w.cond = C_MOD_BUSY; w.target = U_LOAD2;
			end
			U_LOAD2: begin
				w.pa = PA_LOAD; w.pm_we = 1'b1;
				w.jt = J_GOTO; w.target = U_FIN;
			end
			U_FIN: begin
				w.act = ACT_DELIVER;
				w.jt = J_WAIT; w.cond = C_OUT_BUSY; w.target = U_IDLE;
			end
			default: begin
				w.jt = J_GOTO; w.target = U_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tsbc_ram.sv =====
`default_nettype none

module tsbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tsbc_modu.sv =====
`default_nettype none

// Remainder of a 32-bit value by a fixed modulus. Power of two: registered low bits,
// no busy. Otherwise restoring remainder, one bit per cycle.
module tsbc_modu #(
	parameter int MOD = 256
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [31:0]            value,
	output logic                        busy,
	output logic      [$clog2(MOD)-1:0] result
);

	localparam int MA = $clog2(MOD);
	localparam int VW = 32;
	localparam int CW = $clog2(VW);

	generate
		if ((MOD & (MOD - 1)) == 0) begin : g_pow2
			logic [MA-1:0] res_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					res_q <= '0;
				end else if (start) begin
					res_q <= value[MA-1:0];
				end
			end

			assign busy   = 1'b0;
			assign result = res_q;
		end else begin : g_serial
			localparam logic [MA:0] MODV = (MA+1)'(MOD);

			logic          busy_q;
			logic [CW-1:0] cnt_q;
			logic [VW-1:0] val_q;
			logic [MA-1:0] rem_q;
			logic [MA:0]   trial;
			logic [MA:0]   rem_nx;

			always_comb begin
				trial  = {rem_q, val_q[VW-1]};
				rem_nx = (trial >= MODV) ? (trial - MODV) : trial;
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					busy_q <= 1'b0;
					cnt_q  <= '0;
					val_q  <= '0;
					rem_q  <= '0;
				end else if (start) begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
					val_q  <= value;
					rem_q  <= '0;
				end else if (busy_q) begin
					val_q <= {val_q[VW-2:0], 1'b0};
					rem_q <= rem_nx[MA-1:0];
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(VW - 1)) begin
						busy_q <= 1'b0;
					end
				end
			end

			assign busy   = busy_q;
			assign result = rem_q;
		end
	endgenerate

endmodule

`default_nettype wire

// ===== hw/rtl/tsbc_useq.sv =====
`default_nettype none

// Micro-sequencer: step counter, control ROM, wait/goto/dispatch branching.
module tsbc_useq import tsbc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire seq_flags_t flags,
	output ctrl_t           ctrl
);

	uaddr_t upc_q;
	uaddr_t upc_nx;
	uaddr_t disp_tgt;
	logic   cond_hit;

	assign ctrl = ucode_rom(upc_q);

	always_comb begin
		case (ctrl.cond)
			C_NO_XFER:  cond_hit = !flags.in_xfer;
			C_MOD_BUSY: cond_hit = flags.mod_busy;
			C_OUT_BUSY: cond_hit = flags.out_busy;
			C_CLR_MORE: cond_hit = flags.clr_more;
			default:    cond_hit = 1'b0;
		endcase
	end

	always_comb begin
		case (ctrl.dsel)
			D_CMD: begin
				if (flags.cmd_load)     disp_tgt = U_LOAD0;
				else if (flags.stopped) disp_tgt = U_FIN;
				else if (flags.wrem_nz) disp_tgt = U_EMIT0;
				else                    disp_tgt = U_EXEC;
			end
			D_OP: begin
				case (flags.op_code)
					OPC_PUSH:    disp_tgt = flags.dep_full ? U_OVF : U_PUSH_A;
					OPC_ADD:     disp_tgt = flags.dep_lt2 ? U_UNDER : U_ADD0;
					OPC_SYSCALL: disp_tgt = flags.dep_lt1 ? U_UNDER : U_SYS0;
					default:     disp_tgt = U_BADOP;
				endcase
			end
			D_SYS: begin
				case (flags.sys_num)
					SYS_WRITE: disp_tgt = flags.dep_lt3 ? U_UNDER : U_WR0;
					SYS_EXIT:  disp_tgt = flags.dep_lt2 ? U_UNDER : U_EXIT0;
					default:   disp_tgt = U_BADSYS;
				endcase
			end
			default: disp_tgt = U_IDLE;
		endcase
	end

	always_comb begin
		case (ctrl.jt)
			J_NEXT:  upc_nx = uaddr_t'(upc_q + 5'd1);
			J_GOTO:  upc_nx = ctrl.target;
			J_WAIT:  upc_nx = cond_hit ? upc_q : ctrl.target;
			J_DISP:  upc_nx = disp_tgt;
			default: upc_nx = U_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= U_CLR;
		end else begin
			upc_q <= upc_nx;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tiny_stack_bytecode_core.sv =====
`default_nettype none

// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+--------------------------------------
// command  | in        | cmd_valid / cmd_stall   | command, load_address, load_data
// result   | out       | res_valid / res_stall   | byte_valid, out_byte, halted,
//          |           |                         | exit_code, status, fetch_address
//
// One command is in flight at a time; a microprogram runs it over a single-port
// program memory and a single-port stack memory. A push reads four immediate
// bytes. With MEM_BYTES not a power of two, load and write syscall also wait
// for the serial address remainder.
// After reset the program memory is zeroed by a sweep over all MEM_BYTES
// addresses, with cmd_stall high. A command is taken while the previous result
// still waits in the output register; only the final step waits on res_stall.
module tiny_stack_bytecode_core import tsbc_pkg::*; #(
	parameter int MEM_BYTES   = 256,
	parameter int STACK_WORDS = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cmd_valid,
	output logic             cmd_stall,
	input  wire logic        command,
	input  wire logic [7:0]  load_address,
	input  wire logic [7:0]  load_data,

	output logic             res_valid,
	input  wire logic        res_stall,
	output logic             byte_valid,
	output logic      [7:0]  out_byte,
	output logic             halted,
	output logic      [31:0] exit_code,
	output logic      [2:0]  status,
	output logic      [7:0]  fetch_address
);

	localparam int MA  = $clog2(MEM_BYTES);
	localparam int SAW = $clog2(STACK_WORDS);
	localparam int DW  = $clog2(STACK_WORDS + 1);
	localparam int FAW = (MA > 8) ? MA : 8;
	localparam logic [MA:0]   MEMV   = (MA+1)'(MEM_BYTES);
	localparam logic [MA-1:0] CLR_LAST = MA'(MEM_BYTES - 1);
	localparam logic [DW-1:0] DEPTH_FULL = DW'(STACK_WORDS);

	// address + small increment, wrapped at MEM_BYTES
	function automatic logic [MA-1:0] wrap_add(input logic [MA-1:0] base,
	                                           input logic [2:0] inc);
		logic [MA:0] sum;
		logic [MA:0] fix;
		sum = {1'b0, base} + (MA+1)'(inc);
		fix = (sum >= MEMV) ? (sum - MEMV) : sum;
		return fix[MA-1:0];
	endfunction

	ctrl_t      ctrl;
	seq_flags_t flags;

	// latched command
	logic       cmd_q;
	logic [7:0] ld_addr_q;
	logic [7:0] ld_data_q;

	// architectural state
	logic [MA-1:0] ia_q;
	logic [MA-1:0] wp_q;
	logic [MA-1:0] clr_q;
	logic [DW-1:0] depth_q;
	logic [31:0]   wrem_q;
	logic          stopped_q;
	logic [31:0]   final_q;

	// working registers
	logic [31:0] a_q;
	status_t     st_q;
	logic        bv_q;
	logic [7:0]  obyte_q;

	// output register
	logic        res_valid_q;
	logic        res_bv_q;
	logic [7:0]  res_byte_q;
	logic        res_halt_q;
	logic [31:0] res_code_q;
	status_t     res_st_q;
	logic [7:0]  res_fetch_q;

	logic          in_xfer;
	logic          out_busy;
	logic          deliver;
	logic [MA-1:0] pm_addr;
	logic [7:0]    pm_wdata;
	logic [7:0]    pm_rdata;
	logic [SAW-1:0] sk_addr;
	logic [DW-1:0] sk_diff;
	logic [31:0]   sk_rdata;
	logic          mod_start;
	logic [31:0]   mod_value;
	logic          mod_busy;
	logic [MA-1:0] mod_result;
	logic [2:0]    ia_step;
	logic [FAW-1:0] ia_wide;

	tsbc_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	assign cmd_stall = !ctrl.accept;
	assign in_xfer   = cmd_valid && ctrl.accept;
	assign out_busy  = res_valid_q && res_stall;
	assign deliver   = (ctrl.act == ACT_DELIVER) && !out_busy;

	always_comb begin
		flags.in_xfer  = in_xfer;
		flags.mod_busy = mod_busy;
		flags.out_busy = out_busy;
		flags.clr_more = (clr_q != CLR_LAST);
		flags.cmd_load = (cmd_q == CMD_LOAD);
		flags.stopped  = stopped_q;
		flags.wrem_nz  = (wrem_q != 32'd0);
		flags.op_code  = pm_rdata;
		flags.sys_num  = sk_rdata[7:0];
		flags.dep_full = (depth_q == DEPTH_FULL);
		flags.dep_lt1  = (depth_q == DW'(0));
		flags.dep_lt2  = (depth_q < DW'(2));
		flags.dep_lt3  = (depth_q < DW'(3));
	end

	// program memory port
	always_comb begin
		case (ctrl.pa)
			PA_IA:   pm_addr = wrap_add(ia_q, ctrl.ia_off);
			PA_WP:   pm_addr = wp_q;
			PA_LOAD: pm_addr = mod_result;
			PA_CLR:  pm_addr = clr_q;
			default: pm_addr = ia_q;
		endcase
		pm_wdata = (ctrl.pa == PA_CLR) ? 8'd0 : ld_data_q;
	end

	tsbc_ram #(
		.WIDTH (8),
		.DEPTH (MEM_BYTES)
	) u_pmem (
		.clk   (clk),
		.we    (ctrl.pm_we),
		.addr  (pm_addr),
		.wdata (pm_wdata),
		.rdata (pm_rdata)
	);

	// stack memory port: addresses relative to the current depth
	always_comb begin
		case (ctrl.sa)
			SA_PUSH: sk_diff = depth_q;
			SA_TOP:  sk_diff = depth_q - DW'(1);
			SA_TOP1: sk_diff = depth_q - DW'(2);
			SA_TOP2: sk_diff = depth_q - DW'(3);
			default: sk_diff = depth_q;
		endcase
		sk_addr = sk_diff[SAW-1:0];
	end

	tsbc_ram #(
		.WIDTH (32),
		.DEPTH (STACK_WORDS)
	) u_stack (
		.clk   (clk),
		.we    (ctrl.sk_we),
		.addr  (sk_addr),
		.wdata (a_q),
		.rdata (sk_rdata)
	);

	// shared address remainder: load address and write pointer
	assign mod_start = (ctrl.act == ACT_MOD_LOAD) || (ctrl.act == ACT_MOD_PTR);
	assign mod_value = (ctrl.act == ACT_MOD_LOAD) ? 32'(ld_addr_q) : sk_rdata;

	tsbc_modu #(
		.MOD (MEM_BYTES)
	) u_modu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.value  (mod_value),
		.busy   (mod_busy),
		.result (mod_result)
	);

	assign ia_step = (ctrl.ia == IA_ADV5) ? 3'd5 : 3'd1;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ia_q        <= '0;
			wp_q        <= '0;
			clr_q       <= '0;
			depth_q     <= '0;
			wrem_q      <= '0;
			stopped_q   <= 1'b0;
			final_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (ctrl.ia != IA_HOLD) begin
				ia_q <= wrap_add(ia_q, ia_step);
			end

			case (ctrl.dep)
				DP_INC:  depth_q <= depth_q + DW'(1);
				DP_DEC1: depth_q <= depth_q - DW'(1);
				DP_DEC2: depth_q <= depth_q - DW'(2);
				DP_DEC3: depth_q <= depth_q - DW'(3);
				default: depth_q <= depth_q;
			endcase

			case (ctrl.act)
				ACT_SETLEN:   wrem_q <= sk_rdata;
				ACT_SETWP:    wp_q <= mod_result;
				ACT_EMIT_ADV: begin
					wp_q   <= wrap_add(wp_q, 3'd1);
					wrem_q <= wrem_q - 32'd1;
				end
				ACT_SETEXIT: begin
					final_q   <= sk_rdata;
					stopped_q <= 1'b1;
				end
				ACT_CLRINC:   clr_q <= clr_q + MA'(1);
				default: ;
			endcase

			if (deliver) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q     <= command;
			ld_addr_q <= load_address;
			ld_data_q <= load_data;
		end

		if (ctrl.st_we) begin
			st_q <= ctrl.st;
		end

		case (ctrl.act)
			ACT_BEGIN: begin
				bv_q    <= 1'b0;
				obyte_q <= 8'd0;
			end
			ACT_SHIFT:  a_q <= {a_q[23:0], pm_rdata};
			ACT_TAKE_A: a_q <= sk_rdata;
			ACT_SUM:    a_q <= a_q + sk_rdata;
			ACT_OBYTE: begin
				bv_q    <= 1'b1;
				obyte_q <= pm_rdata;
			end
			default: ;
		endcase

		if (deliver) begin
			res_bv_q    <= bv_q;
			res_byte_q  <= obyte_q;
			res_halt_q  <= stopped_q;
			res_code_q  <= final_q;
			res_st_q    <= st_q;
			res_fetch_q <= ia_wide[7:0];
		end
	end

	assign ia_wide = FAW'(ia_q);

	assign res_valid     = res_valid_q;
	assign byte_valid    = res_bv_q;
	assign out_byte      = res_byte_q;
	assign halted        = res_halt_q;
	assign exit_code     = res_code_q;
	assign status        = res_st_q;
	assign fetch_address = res_fetch_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tsbc_checker.sv =====
`default_nettype none

module tsbc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cmd_valid,
	input wire logic        cmd_stall,
	input wire logic        res_valid,
	input wire logic        res_stall,
	input wire logic        byte_valid,
	input wire logic [7:0]  out_byte,
	input wire logic        halted,
	input wire logic [31:0] exit_code,
	input wire logic [2:0]  status,
	input wire logic [7:0]  fetch_address
);

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid &&
		$stable({byte_valid, out_byte, halted, exit_code, status, fetch_address}))
		else $error("result changed while stalled");

	// one command at a time: a transfer closes the port on the next cycle
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("command port open right after a transfer");

	// halt is sticky
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && halted |=> halted)
		else $error("halted dropped");

	// exit code frozen once halted
	a_code_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && halted |=> $stable(exit_code))
		else $error("exit code changed after halt");

endmodule

bind tiny_stack_bytecode_core tsbc_checker u_tsbc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd_valid),
	.cmd_stall     (cmd_stall),
	.res_valid     (res_valid),
	.res_stall     (res_stall),
	.byte_valid    (byte_valid),
	.out_byte      (out_byte),
	.halted        (halted),
	.exit_code     (exit_code),
	.status        (status),
	.fetch_address (fetch_address)
);

`default_nettype wire
